[rtl/core/chr_pkg.sv]
// Shared constants and types for the compressor hysteresis regulator.
`default_nettype none

package chr_pkg;

    localparam int unsigned PSI_W     = 10;
    localparam int unsigned HYST_W    = 8;
    localparam int unsigned COOL_W    = 12;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned MS_PER_S  = 1000;
    // 4095 s * 1000 ms fits in 22 bits
    localparam int unsigned LIMIT_W   = 22;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOP = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_IDLE = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_RUN_TGT   = 3'd1,
        REG_IDLE_TGT  = 3'd2,
        REG_HYST      = 3'd3,
        REG_MAX_PSI   = 3'd4,
        REG_COOL_TIME = 3'd5,
        REG_SPARE6    = 3'd6,
        REG_SPARE7    = 3'd7
    } t_cfg_reg;

    localparam logic [HYST_W-1:0]  HYST_RST     = 8'd5;
    localparam logic [PSI_W-1:0]   MAX_PSI_RST  = 10'd150;
    localparam logic [LIMIT_W-1:0] LIMIT_MS_RST = 22'd600000;

endpackage

`default_nettype wire

[rtl/core/compressor_hysteresis_regulator.sv]
// Top level of the compressor hysteresis regulator: config registers, motor state, result register.
`default_nettype none

// One pressure sample with its millisecond timestamp goes in per item and one
// result (motor on, cooldown pending, run state) comes out per item. The decision
// is made in the cycle of acceptance and lands in the result register at that
// edge, so items can follow on every clock while results are taken as fast as
// they come. The input side is ready whenever the result register is empty or
// is being emptied in the same cycle. The cool time is stored as a millisecond
// limit, worked out at the configuration write, so the per-item path is one
// 32-bit subtract and compare. Elapsed time wraps modulo 2^32. Write
// configuration only while idle.
module compressor_hysteresis_regulator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [chr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [chr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input items
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [chr_pkg::PSI_W-1:0]      i_pressure_psi,
    input  wire logic [chr_pkg::TIME_W-1:0]     i_now_ms,
    // result items
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic                           o_motor_on,
    output      logic                           o_in_cooldown,
    output      logic [chr_pkg::MODE_W-1:0]     o_run_state
);

    // Configuration registers
    chr_pkg::t_mode                r_mode;
    logic [chr_pkg::PSI_W-1:0]     r_run_tgt;
    logic [chr_pkg::PSI_W-1:0]     r_idle_tgt;
    logic [chr_pkg::HYST_W-1:0]    r_hyst;
    logic [chr_pkg::PSI_W-1:0]     r_max_psi;
    logic [chr_pkg::LIMIT_W-1:0]   r_limit_ms;

    // Regulator state
    logic                          r_motor;
    logic                          r_cool;
    logic [chr_pkg::TIME_W-1:0]    r_last_ms;

    // Result register
    logic                          r_out_valid;
    logic                          r_out_motor;
    logic                          r_out_cool;
    logic [chr_pkg::MODE_W-1:0]    r_out_state;

    logic                          n_motor;
    logic                          n_cool;
    logic [chr_pkg::TIME_W-1:0]    n_last_ms;
    logic [chr_pkg::MODE_W-1:0]    n_state;
    logic [chr_pkg::LIMIT_W-1:0]   n_limit_ms;

    logic                          accept;
    logic                          active;
    logic [chr_pkg::PSI_W-1:0]     tgt;
    logic [chr_pkg::PSI_W:0]       p_plus_hyst;
    logic [chr_pkg::PSI_W:0]       tgt_plus_hyst;
    logic [chr_pkg::TIME_W-1:0]    elapsed_old;
    logic                          old_expired;
    logic                          zero_expired;
    logic                          start;
    logic                          stop;
    logic                          trip;
    logic                          touched;
    logic                          cool_kept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    assign o_out_valid   = r_out_valid;
    assign o_motor_on    = r_out_motor;
    assign o_in_cooldown = r_out_cool;
    assign o_run_state   = r_out_state;

    // Seconds to milliseconds: constant multiply, done once per config write
    assign n_limit_ms = chr_pkg::LIMIT_W'(i_cfg_wdata) * chr_pkg::LIMIT_W'(chr_pkg::MS_PER_S);

    always_comb begin
        active = (r_mode == chr_pkg::MODE_RUN) || (r_mode == chr_pkg::MODE_IDLE);
        tgt    = (r_mode == chr_pkg::MODE_IDLE) ? r_idle_tgt : r_run_tgt;

        // p < tgt - hyst, rewritten without a negative threshold
        p_plus_hyst   = {1'b0, i_pressure_psi} + (chr_pkg::PSI_W + 1)'(r_hyst);
        tgt_plus_hyst = {1'b0, tgt} + (chr_pkg::PSI_W + 1)'(r_hyst);

        elapsed_old  = i_now_ms - r_last_ms;
        old_expired  = elapsed_old >= chr_pkg::TIME_W'(r_limit_ms);
        // once the timestamp is refreshed the elapsed time is zero
        zero_expired = (r_limit_ms == '0);

        start = active && !r_motor && !r_cool && (p_plus_hyst < {1'b0, tgt});
        stop  = ({1'b0, i_pressure_psi} >= tgt_plus_hyst) || (i_pressure_psi >= r_max_psi);

        n_motor   = 1'b0;
        n_cool    = r_cool;
        n_last_ms = r_last_ms;
        touched   = 1'b0;
        trip      = 1'b0;

        if (active) begin
            if (r_motor || start) begin
                // run limit: a start or stop this step restarts the clock
                trip    = (start || stop) ? zero_expired : old_expired;
                n_motor = !stop && !trip;
                touched = start || stop || trip;
                n_cool  = r_cool || trip;
            end
        end else begin
            touched = 1'b1;
        end

        if (touched) begin
            n_last_ms = i_now_ms;
        end

        // drop a pending cooldown once the cool time has passed
        cool_kept = touched ? !zero_expired : !old_expired;
        n_cool    = n_cool && cool_kept;

        n_state = active ? r_mode : chr_pkg::MODE_STOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= chr_pkg::MODE_STOP;
            r_run_tgt   <= '0;
            r_idle_tgt  <= '0;
            r_hyst      <= chr_pkg::HYST_RST;
            r_max_psi   <= chr_pkg::MAX_PSI_RST;
            r_limit_ms  <= chr_pkg::LIMIT_MS_RST;
            r_motor     <= 1'b0;
            r_cool      <= 1'b0;
            r_last_ms   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (chr_pkg::t_cfg_reg'(i_cfg_idx))
                    chr_pkg::REG_MODE: begin
                        r_mode <= chr_pkg::t_mode'(i_cfg_wdata[chr_pkg::MODE_W-1:0]);
                    end
                    chr_pkg::REG_RUN_TGT:   r_run_tgt  <= i_cfg_wdata[chr_pkg::PSI_W-1:0];
                    chr_pkg::REG_IDLE_TGT:  r_idle_tgt <= i_cfg_wdata[chr_pkg::PSI_W-1:0];
                    chr_pkg::REG_HYST:      r_hyst     <= i_cfg_wdata[chr_pkg::HYST_W-1:0];
                    chr_pkg::REG_MAX_PSI:   r_max_psi  <= i_cfg_wdata[chr_pkg::PSI_W-1:0];
                    chr_pkg::REG_COOL_TIME: r_limit_ms <= n_limit_ms;
                    default: ;
                endcase
            end

            // advance the regulator state on each accepted item
            if (accept) begin
                r_motor   <= n_motor;
                r_cool    <= n_cool;
                r_last_ms <= n_last_ms;
            end

            // hold the result until taken; refill in the same cycle
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_motor <= n_motor;
            r_out_cool  <= n_cool;
            r_out_state <= n_state;
        end
    end

endmodule

`default_nettype wire
